@@ design/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the single-Gaussian background subtractor.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int INDEX_W  = 16;
    localparam int PIXEL_W  = 8;
    localparam int SUM_W    = 16;
    localparam int SQSUM_W  = 24;
    localparam int FCOUNT_W = 9;

    // train_frames is 8 bits wide, so the clamp fits in 8 bits as well
    localparam logic [7:0] MAX_TRAIN_FRAMES = 8'd255;

    // register map
    localparam int         CFG_ADDR_W       = 3;
    localparam logic       REG_TRAIN_FRAMES = 1'b0;
    localparam logic       REG_WEIGHT_Q8    = 1'b1;
    localparam logic [7:0]  TRAIN_FRAMES_RST = 8'd200;
    localparam logic [15:0] WEIGHT_Q8_RST    = 16'd256;

    localparam logic [7:0] MASK_FG = 8'd255;
    localparam logic [7:0] MASK_BG = 8'd0;
    localparam logic [7:0] SAT_8   = 8'd255;

    typedef struct packed {
        logic [SQSUM_W-1:0] sq;
        logic [SUM_W-1:0]   sum;
    } t_acc_word;

    typedef struct packed {
        logic [7:0] mean;
        logic [7:0] thr;
    } t_model_word;

    // zero means one frame; anything above the ceiling is clamped
    function automatic logic [7:0] eff_frames(input logic [7:0] tf);
        logic [7:0] n;
        n = tf;
        if (n == 8'd0) n = 8'd1;
        if (n > MAX_TRAIN_FRAMES) n = MAX_TRAIN_FRAMES;
        return n;
    endfunction

endpackage

@@ design/gaussian_background_subtractor_core.sv @@
// ----------------------------------------------------------------------------
// gaussian_background_subtractor_core
// Per-pixel mean/deviation background model with foreground mask output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one grey pixel per request
//   with its raster index and end-of-frame flag. Output channel
//   (o_out_valid / i_out_stall) returns one mask per pixel, only in frames
//   after the model was built. Registers are to be written over the APB port
//   only while the block is idle; the block itself does not enforce this.
//   A training or classification request does the synchronous memory read,
//   then writes back or classifies; a model-build request makes two passes
//   through the shared 8-step radix-2 divider plus the multiply chain. An
//   index outside the frame leaves the block idle in training and
//   model-build frames. o_out_valid rises once the classify state has
//   loaded the output register, which waits while i_out_stall holds it full.
//   After reset every accumulator entry is swept to zero, one entry a cycle;
//   o_in_stall stays high meanwhile.
//   A pending mask sits in an output register; the next request is still
//   taken, and a following mask waits only while i_out_stall holds the
//   register full.
// ----------------------------------------------------------------------------
module gaussian_background_subtractor_core #(
    parameter int FRAME_PIXELS = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // pixel input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [gbs_pkg::PIXEL_W-1:0]     i_pixel,
    input  logic [gbs_pkg::INDEX_W-1:0]     i_pixel_index,
    input  logic                            i_end_of_frame,
    // mask output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_mask,
    output logic [gbs_pkg::INDEX_W-1:0]     o_out_index,
    output logic                            o_out_last
);
    import gbs_pkg::*;

    localparam int DEPTH = (FRAME_PIXELS < (2 ** INDEX_W)) ? FRAME_PIXELS : (2 ** INDEX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_TRN_WR  = 4'd2;
    localparam logic [3:0] S_BLD_LD  = 4'd3;
    localparam logic [3:0] S_MDIV    = 4'd4;
    localparam logic [3:0] S_MUL1    = 4'd5;
    localparam logic [3:0] S_MUL2    = 4'd6;
    localparam logic [3:0] S_DEV     = 4'd7;
    localparam logic [3:0] S_MUL3    = 4'd8;
    localparam logic [3:0] S_TLD     = 4'd9;
    localparam logic [3:0] S_TDIV    = 4'd10;
    localparam logic [3:0] S_CLS_OUT = 4'd11;

    // control
    logic [3:0]          r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [FCOUNT_W-1:0] r_frame_count;
    logic [7:0]          r_train_frames;
    logic [15:0]         r_weight_q8;
    logic [2:0]          r_div_cnt;
    logic                r_out_valid;

    // item and datapath
    logic [PIXEL_W-1:0]  r_pix;
    logic [INDEX_W-1:0]  r_idx;
    logic                r_eof;
    logic                r_ok;
    logic [7:0]          r_n;
    logic [SUM_W-1:0]    r_s;
    logic [SQSUM_W-1:0]  r_q;
    logic [7:0]          r_m;
    logic [15:0]         r_mm;
    logic [23:0]         r_ms;
    logic [23:0]         r_nmm;
    logic [24:0]         r_dev;
    logic [40:0]         r_prod;
    logic [7:0]          r_rem;
    logic [7:0]          r_dlow;
    logic [7:0]          r_quo;
    logic                r_sat;
    logic [7:0]          r_mask;
    logic [INDEX_W-1:0]  r_out_index;
    logic                r_out_last;

    // memories
    t_acc_word           r_acc_mem [DEPTH];
    t_acc_word           r_acc_rd;
    t_model_word         r_mdl_mem [DEPTH];
    t_model_word         r_mdl_rd;

    logic                cfg_wr;
    logic                in_accept;
    logic                in_ok;
    logic [7:0]          n_eff;
    logic                out_free;
    logic                out_load;
    logic [7:0]          cls_diff;
    logic [7:0]          cls_mask;
    logic                mem_re;
    logic                acc_we;
    logic [AW-1:0]       acc_waddr;
    t_acc_word           acc_wdata;
    logic                mdl_we;
    t_model_word         mdl_wdata;
    logic [8:0]          div_t;
    logic                div_ge;
    logic [7:0]          div_rem_nx;
    logic [7:0]          div_quo_nx;
    logic [24:0]         dev_pos;
    logic [24:0]         dev_neg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_train_frames <= TRAIN_FRAMES_RST;
            r_weight_q8    <= WEIGHT_Q8_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TRAIN_FRAMES: r_train_frames <= pwdata[7:0];
                REG_WEIGHT_Q8:    r_weight_q8    <= pwdata[15:0];
                default:          r_train_frames <= r_train_frames;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TRAIN_FRAMES: prdata = {24'd0, r_train_frames};
            REG_WEIGHT_Q8:    prdata = {16'd0, r_weight_q8};
            default:          prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_ok      = (32'(i_pixel_index) < 32'(FRAME_PIXELS));
    assign n_eff      = eff_frames(r_train_frames);

    // ---------------- shared restoring divider step ----------------
    always_comb begin
        div_t      = {r_rem, r_dlow[7]};
        div_ge     = (div_t >= {1'b0, r_n});
        div_rem_nx = div_ge ? 8'(div_t - {1'b0, r_n}) : div_t[7:0];
        div_quo_nx = {r_quo[6:0], div_ge};
    end

    always_comb begin
        dev_pos = 25'(r_q) + 25'(r_nmm);
        dev_neg = {r_ms, 1'b0};
    end

    // ---------------- classification ----------------
    always_comb begin
        cls_diff = (r_pix > r_mdl_rd.mean) ? (r_pix - r_mdl_rd.mean)
                                           : (r_mdl_rd.mean - r_pix);
        cls_mask = (r_ok && (cls_diff > r_mdl_rd.thr)) ? MASK_FG : MASK_BG;
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_CLS_OUT) && out_free;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (r_frame_count < {1'b0, n_eff}) begin
                        n_state = in_ok ? S_TRN_WR : S_IDLE;
                    end else if (r_frame_count == {1'b0, n_eff}) begin
                        n_state = in_ok ? S_BLD_LD : S_IDLE;
                    end else begin
                        n_state = S_CLS_OUT;
                    end
                end
            end
            S_TRN_WR: n_state = S_IDLE;
            S_BLD_LD: n_state = S_MDIV;
            S_MDIV: begin
                if (r_div_cnt == 3'd7) n_state = S_MUL1;
            end
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_DEV;
            S_DEV:    n_state = S_MUL3;
            S_MUL3:   n_state = S_TLD;
            S_TLD:    n_state = S_TDIV;
            S_TDIV: begin
                if (r_div_cnt == 3'd7) n_state = S_IDLE;
            end
            S_CLS_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_frame_count <= '0;
            r_div_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (in_accept && i_end_of_frame && (r_frame_count <= {1'b0, n_eff})) begin
                r_frame_count <= r_frame_count + FCOUNT_W'(1);
            end
            if ((r_state == S_MDIV) || (r_state == S_TDIV)) begin
                r_div_cnt <= r_div_cnt + 3'd1;
            end else begin
                r_div_cnt <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix <= i_pixel;
            r_idx <= i_pixel_index;
            r_eof <= i_end_of_frame;
            r_ok  <= in_ok;
            r_n   <= n_eff;
        end
        case (r_state)
            S_BLD_LD: begin
                r_s   <= r_acc_rd.sum;
                r_q   <= r_acc_rd.sq;
                // mean saturates when sum >= 256*n
                r_sat  <= (r_acc_rd.sum[15:8] >= r_n);
                r_rem  <= r_acc_rd.sum[15:8];
                r_dlow <= r_acc_rd.sum[7:0];
                r_quo  <= '0;
            end
            S_MDIV, S_TDIV: begin
                r_rem  <= div_rem_nx;
                r_dlow <= {r_dlow[6:0], 1'b0};
                r_quo  <= div_quo_nx;
                if ((r_state == S_MDIV) && (r_div_cnt == 3'd7)) begin
                    r_m <= r_sat ? SAT_8 : div_quo_nx;
                end
            end
            S_MUL1: begin
                r_mm <= 16'(r_m) * 16'(r_m);
                r_ms <= 24'(r_m) * 24'(r_s);
            end
            S_MUL2: begin
                r_nmm <= 24'(r_n) * 24'(r_mm);
            end
            S_DEV: begin
                r_dev <= (dev_pos > dev_neg) ? (dev_pos - dev_neg) : '0;
            end
            S_MUL3: begin
                r_prod <= 41'(r_weight_q8) * 41'(r_dev);
            end
            S_TLD: begin
                // numerator is prod/256; threshold saturates when that is >= 256*n
                r_sat  <= (r_prod[40:16] >= 25'(r_n));
                r_rem  <= r_prod[23:16];
                r_dlow <= r_prod[15:8];
                r_quo  <= '0;
            end
            default: begin
                r_quo <= r_quo;
            end
        endcase
        if (out_load) begin
            r_mask      <= cls_mask;
            r_out_index <= r_idx;
            r_out_last  <= r_eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mask      = r_mask;
    assign o_out_index = r_out_index;
    assign o_out_last  = r_out_last;

    // ---------------- memories ----------------
    assign mem_re = (r_state == S_IDLE);

    always_comb begin
        if (r_state == S_CLEAR) begin
            acc_we    = 1'b1;
            acc_waddr = r_clr_addr;
            acc_wdata = '0;
        end else begin
            acc_we        = (r_state == S_TRN_WR);
            acc_waddr     = r_idx[AW-1:0];
            acc_wdata.sum = r_acc_rd.sum + SUM_W'(r_pix);
            acc_wdata.sq  = r_acc_rd.sq + SQSUM_W'(16'(r_pix) * 16'(r_pix));
        end
    end

    assign mdl_we         = (r_state == S_TDIV) && (r_div_cnt == 3'd7);
    assign mdl_wdata.mean = r_m;
    assign mdl_wdata.thr  = r_sat ? SAT_8 : div_quo_nx;

    always_ff @(posedge i_clk) begin
        if (acc_we) r_acc_mem[acc_waddr] <= acc_wdata;
        if (mem_re) r_acc_rd <= r_acc_mem[i_pixel_index[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (mdl_we) r_mdl_mem[r_idx[AW-1:0]] <= mdl_wdata;
        if (mem_re) r_mdl_rd <= r_mdl_mem[i_pixel_index[AW-1:0]];
    end

    // ---------------- assertions ----------------
    a_fcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_count <= FCOUNT_W'(256))
        else $error("frame count ran past its hold value");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLS_OUT) && r_out_valid && i_out_stall |=> (r_state == S_CLS_OUT))
        else $error("mask left while the output register was still full");

    a_mul_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> ($past(r_state) == S_MDIV) && ($past(r_div_cnt) == 3'd7))
        else $error("multiply chain entered before the mean divide finished");

    a_model_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdl_we |-> r_ok && !acc_we)
        else $error("model write for an out-of-range index or during accumulation");

endmodule
